// ===== hdl/pcu_pkg.sv =====
// ----------------------------------------------------------------------------
// pcu_pkg
// Types, widths and operation codes shared by the correlation unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcu_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 29;
    localparam int SUM_XY_W    = 44;
    localparam int SUM_SQ_W    = 43;
    localparam int WORK_W      = 128;
    localparam int HALF_W      = 64;
    localparam int STEP_W      = 7;
    localparam int CORR_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int FRAC_SHIFT  = 15;

    localparam logic [CNT_W-1:0]  MAX_SAMPLES = CNT_W'(4096);
    localparam logic [STEP_W-1:0] LAST_MUL    = STEP_W'(63);
    localparam logic [STEP_W-1:0] LAST_SQRT   = STEP_W'(63);
    localparam logic [STEP_W-1:0] LAST_DIV    = STEP_W'(127);
    localparam logic [CORR_W-1:0] CORR_ONE    = CORR_W'(16384);

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_DEN = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    // datapath operations, run in this order
    localparam logic [3:0] OP_N_SXY  = 4'd0;
    localparam logic [3:0] OP_SX_SY  = 4'd1;
    localparam logic [3:0] OP_N_SXX  = 4'd2;
    localparam logic [3:0] OP_SX_SX  = 4'd3;
    localparam logic [3:0] OP_N_SYY  = 4'd4;
    localparam logic [3:0] OP_SY_SY  = 4'd5;
    localparam logic [3:0] OP_VA_VB  = 4'd6;
    localparam logic [3:0] OP_SQRT   = 4'd7;
    localparam logic [3:0] OP_DIV    = 4'd8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic                       last_pair;
    } t_in_word;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         pair_count;
    } t_out_word;

    typedef struct packed {
        logic       acc;
        logic       start;
        logic [3:0] op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic n_lt2;
        logic den_zero;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/pcu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcu_ctrl
// Sequencer: accepts words, walks the datapath through the final arithmetic
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcu_ctrl
    import pcu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_last,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       s_in_acc, s_slot_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign s_in_acc    = i_in_valid && !o_in_stall;
    assign s_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        o_cmd.acc    = s_in_acc;
        case (r_state)
            ST_IDLE: begin
                if (s_in_acc && i_in_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.n_lt2) begin
                    n_state = ST_FINISH;
                end else begin
                    n_op    = OP_N_SXY;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    if (r_op == OP_DIV || (r_op == OP_SQRT && i_stat.den_zero)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_op    = r_op + 4'd1;
                        n_state = ST_START;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (s_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_N_SXY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pcu_dp.sv =====
// ----------------------------------------------------------------------------
// pcu_dp
// Sums, a shift-add multiplier, a restoring square root and a restoring
// divider, all sharing one step counter, plus the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcu_dp
    import pcu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_word i_in_data,
    input  wire t_cmd     i_cmd,
    output t_stat         o_stat,
    output t_out_word     o_out_data
);

    logic [CNT_W-1:0]           r_cnt;
    logic signed [SUM_W-1:0]    r_sx, r_sy;
    logic signed [SUM_XY_W-1:0] r_sxy;
    logic [SUM_SQ_W-1:0]        r_sxx, r_syy;
    logic                       r_ovf;

    logic                r_busy, r_done;
    logic [3:0]          r_op;
    logic [STEP_W-1:0]   r_step;
    logic [WORK_W-1:0]   r_acc, r_ma, r_t, r_num, r_va, r_vb, r_v;
    logic [HALF_W-1:0]   r_mb, r_den;
    logic                r_neg;
    logic [WORK_W-1:0]   r_rem, r_res, r_bit;
    logic [WORK_W-1:0]   r_dn, r_r, r_q;
    t_out_word           r_out;

    logic signed [2*SAMPLE_W-1:0] s_pxy, s_pxx, s_pyy;
    logic [HALF_W-1:0]   s_a, s_b;
    logic                s_neg;
    logic [WORK_W-1:0]   n_acc, s_prod;
    logic [WORK_W-1:0]   s_sq_t, n_rem, n_res;
    logic [WORK_W-1:0]   s_d, s_rr, n_r, n_q;
    logic [WORK_W-1:0]   s_mag;
    logic [STEP_W-1:0]   s_last;
    logic                s_fin;
    logic [CORR_W-1:0]   s_m;
    t_out_word           s_out;

    function automatic logic [HALF_W-1:0] mag64(input logic [HALF_W-1:0] v);
        return v[HALF_W-1] ? (HALF_W'(0) - v) : v;
    endfunction

    assign s_pxy = i_in_data.x_sample * i_in_data.y_sample;
    assign s_pxx = i_in_data.x_sample * i_in_data.x_sample;
    assign s_pyy = i_in_data.y_sample * i_in_data.y_sample;

    // operand select for a multiply start
    always_comb begin
        s_a   = '0;
        s_b   = '0;
        s_neg = 1'b0;
        case (i_cmd.op)
            OP_N_SXY: begin
                s_a   = HALF_W'(r_cnt);
                s_b   = mag64(HALF_W'(r_sxy));
                s_neg = r_sxy[SUM_XY_W-1];
            end
            OP_SX_SY: begin
                s_a   = mag64(HALF_W'(r_sx));
                s_b   = mag64(HALF_W'(r_sy));
                s_neg = r_sx[SUM_W-1] ^ r_sy[SUM_W-1];
            end
            OP_N_SXX: begin
                s_a = HALF_W'(r_cnt);
                s_b = HALF_W'(r_sxx);
            end
            OP_SX_SX: begin
                s_a = mag64(HALF_W'(r_sx));
                s_b = s_a;
            end
            OP_N_SYY: begin
                s_a = HALF_W'(r_cnt);
                s_b = HALF_W'(r_syy);
            end
            OP_SY_SY: begin
                s_a = mag64(HALF_W'(r_sy));
                s_b = s_a;
            end
            OP_VA_VB: begin
                s_a = r_va[HALF_W-1:0];
                s_b = r_vb[HALF_W-1:0];
            end
            default: begin
                s_a = '0;
            end
        endcase
    end

    // one step of each iterative unit
    always_comb begin
        n_acc  = r_mb[0] ? (r_acc + r_ma) : r_acc;
        s_prod = r_neg ? (WORK_W'(0) - n_acc) : n_acc;

        s_sq_t = r_res + r_bit;
        if (r_rem >= s_sq_t) begin
            n_rem = r_rem - s_sq_t;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end

        s_d  = {{(WORK_W-HALF_W-1){1'b0}}, r_den, 1'b0};
        s_rr = {r_r[WORK_W-2:0], r_dn[WORK_W-1]};
        if (s_rr >= s_d) begin
            n_r = s_rr - s_d;
            n_q = {r_q[WORK_W-2:0], 1'b1};
        end else begin
            n_r = s_rr;
            n_q = {r_q[WORK_W-2:0], 1'b0};
        end

        s_mag = r_num[WORK_W-1] ? (WORK_W'(0) - r_num) : r_num;

        if (r_op == OP_DIV) begin
            s_last = LAST_DIV;
        end else if (r_op == OP_SQRT) begin
            s_last = LAST_SQRT;
        end else begin
            s_last = LAST_MUL;
        end
        s_fin = r_busy && (r_step == s_last);
    end

    // result word
    always_comb begin
        s_m = (r_q > WORK_W'(CORR_ONE)) ? CORR_ONE : r_q[CORR_W-1:0];
        s_out.pair_count = r_cnt;
        if (r_cnt < CNT_W'(2)) begin
            s_out.correlation = '0;
            s_out.status      = STAT_FEW;
        end else begin
            if (r_den == '0) begin
                s_out.correlation = '0;
            end else begin
                s_out.correlation = r_num[WORK_W-1] ? (CORR_W'(0) - s_m) : s_m;
            end
            if (r_ovf) begin
                s_out.status = STAT_OVERFLOW;
            end else if (r_den == '0) begin
                s_out.status = STAT_ZERO_DEN;
            end else begin
                s_out.status = STAT_OK;
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.n_lt2    = (r_cnt < CNT_W'(2));
    assign o_stat.den_zero = (r_den == '0);
    assign o_out_data      = r_out;

    // sums and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxy  <= '0;
            r_sxx  <= '0;
            r_syy  <= '0;
            r_ovf  <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_N_SXY;
            r_step <= '0;
        end else begin
            r_done <= s_fin;
            if (i_cmd.out_load) begin
                r_cnt <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
                r_syy <= '0;
                r_ovf <= 1'b0;
            end else if (i_cmd.acc) begin
                if (r_cnt < MAX_SAMPLES) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_sx  <= r_sx + SUM_W'(i_in_data.x_sample);
                    r_sy  <= r_sy + SUM_W'(i_in_data.y_sample);
                    r_sxy <= r_sxy + SUM_XY_W'(s_pxy);
                    r_sxx <= r_sxx + SUM_SQ_W'(unsigned'(s_pxx));
                    r_syy <= r_syy + SUM_SQ_W'(unsigned'(s_pyy));
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_step <= '0;
            end else if (s_fin) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= s_out;
        end
        if (i_cmd.start) begin
            r_acc <= '0;
            r_ma  <= WORK_W'(s_a);
            r_mb  <= s_b;
            r_neg <= s_neg;
            r_rem <= r_v;
            r_res <= '0;
            r_bit <= {2'b01, {(WORK_W-2){1'b0}}};
            r_dn  <= (s_mag << FRAC_SHIFT) + WORK_W'(r_den);
            r_r   <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_op == OP_SQRT) begin
                r_rem <= n_rem;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                if (s_fin) begin
                    r_den <= n_res[HALF_W-1:0];
                end
            end else if (r_op == OP_DIV) begin
                r_r  <= n_r;
                r_q  <= n_q;
                r_dn <= r_dn << 1;
            end else begin
                r_acc <= n_acc;
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb >> 1;
                if (s_fin) begin
                    case (r_op)
                        OP_N_SXY, OP_N_SXX, OP_N_SYY: r_t <= s_prod;
                        OP_SX_SY: r_num <= r_t - s_prod;
                        OP_SX_SX: r_va  <= r_t - s_prod;
                        OP_SY_SY: r_vb  <= r_t - s_prod;
                        OP_VA_VB: r_v   <= n_acc;
                        default:  r_t   <= r_t;
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pearson_correlation_unit.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation_unit
// Streaming Pearson correlation of paired Q1.15 samples, result in Q2.14.
// ----------------------------------------------------------------------------
// A pair is taken every cycle while the unit collects a set; each word is
// added into the running sums, up to 4096 pairs, after which further pairs
// set the overflow status. The word marked last_pair starts the final
// computation: seven 64-step shift-add multiplies, a 64-step square root and
// a 128-step divide on one shared step counter, each passing through a start
// state and then waiting for done. o_in_stall stays high until the result is
// loaded; a zero denominator skips the divide. Sets with fewer than two pairs
// skip the arithmetic. The result word is valid from the cycle in which the
// stall drops; if the previous result has not been taken yet, the stall
// lasts until it is. The result waits in an output register, so the next
// set can be collected while it is not yet taken.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_unit
    import pcu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_word     o_out_data
);

    t_cmd  s_cmd;
    t_stat s_stat;

    pcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_pair),
        .i_out_stall (i_out_stall),
        .i_stat      (s_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (s_cmd)
    );

    pcu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (s_cmd),
        .o_stat     (s_stat),
        .o_out_data (o_out_data)
    );

`ifndef SYNTH
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last_pair) |=> o_in_stall)
        else $error("input not stalled after last pair");

    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.correlation <= 16'sd16384) &&
                         (o_out_data.correlation >= -16'sd16384)))
        else $error("correlation out of range");

    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_FEW)) |->
            (o_out_data.correlation == '0))
        else $error("short set gave nonzero correlation");
`endif

endmodule

`default_nettype wire
